### hw/rtl/scc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_pkg
// Shared types and constants for the strongly connected components block.
// ----------------------------------------------------------------------------
package scc_pkg;

  localparam int SCC_MAX_VERTICES = 64;
  localparam int SCC_MAX_EDGES    = 256;

  localparam int VTX_W  = 7;
  localparam int COMP_W = 6;
  localparam int KIND_W = 2;

  localparam logic [VTX_W-1:0] NV_RESET = 7'd64;

  localparam logic [KIND_W-1:0] KIND_ADD   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RUN   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;
  localparam logic [KIND_W-1:0] KIND_RSVD  = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [VTX_W-1:0]  src_vertex;
    logic [VTX_W-1:0]  dst_vertex;
  } in_item_t;

  typedef struct packed {
    logic [VTX_W-1:0]  vertex;
    logic [COMP_W-1:0] component;
    logic              last;
    logic              overflow;
  } out_item_t;

  typedef struct packed {
    logic [VTX_W-1:0] src;
    logic [VTX_W-1:0] dst;
  } edge_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_P1_NEXT,
    S_RD,
    S_CMP,
    S_POP,
    S_P2_RD,
    S_P2_CHK,
    S_DONE
  } scc_state_t;

endpackage

### hw/rtl/strongly_connected_components.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strongly_connected_components
// Add-edge and clear items are taken in the idle state and the block is ready
// again the next cycle. A run item occupies the block until its last result has
// left the hold stage: both depth-first passes share one edge-scan unit that
// reads the edge table one entry at a time and can stall while the result side
// is blocked. Results stream out during the second pass; one result is held
// back so the final one carries last.
// ----------------------------------------------------------------------------
module strongly_connected_components
  import scc_pkg::*;
#(
  parameter int MAX_VERTICES = SCC_MAX_VERTICES,
  parameter int MAX_EDGES    = SCC_MAX_EDGES
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_item,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_item,
  input  logic             cfg_we,
  input  logic [VTX_W-1:0] cfg_wdata
);

  localparam int VW  = $clog2(MAX_VERTICES + 1);
  localparam int SW  = $clog2(MAX_VERTICES);
  localparam int EW  = $clog2(MAX_EDGES + 1);
  localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam logic [VTX_W-1:0] NMAX  = VTX_W'(MAX_VERTICES);
  localparam logic [EW-1:0]    EFULL = EW'(MAX_EDGES);

  typedef struct packed {
    logic [VTX_W-1:0] vertex;
    logic [EW-1:0]    cursor;
  } stk_ent_t;

  scc_state_t state_r, state_nxt;

  logic [VTX_W-1:0]  nv_r, nv_nxt;
  logic [EW-1:0]     edge_cnt_r, edge_cnt_nxt;
  logic              drop_r, drop_nxt;
  logic [MAX_VERTICES:0] vis_r, vis_nxt;
  logic              second_r, second_nxt;
  logic [VTX_W-1:0]  idx_r, idx_nxt;
  logic [VTX_W-1:0]  key_r, key_nxt;
  logic [COMP_W-1:0] comp_r, comp_nxt;
  logic [VTX_W-1:0]  u_r, u_nxt;
  logic [EW-1:0]     c_r, c_nxt;
  logic [SW-1:0]     sp_r, sp_nxt;
  out_item_t         hold_r, hold_nxt;
  logic              hold_v_r, hold_v_nxt;
  out_item_t         out_r, out_nxt;
  logic              out_v_r, out_v_nxt;

  logic [VTX_W-1:0] n_act;
  logic             accept;
  logic             add_ok;
  logic             can_emit;
  logic             emit_block;
  logic             emit_req;
  logic [VTX_W-1:0] emit_vtx;

  logic             e_we;
  logic             e_rd;
  edge_t            e_wdata;
  edge_t            edge_q;
  logic [VTX_W-1:0] ea;
  logic [VTX_W-1:0] eb;
  logic             found;

  stk_ent_t         stk_mem [MAX_VERTICES];
  logic             st_we;
  logic             st_rd;
  logic [SW-1:0]    st_raddr;
  stk_ent_t         st_q;

  logic [VTX_W-1:0] fin_mem [MAX_VERTICES];
  logic             fin_we;
  logic [VTX_W-1:0] key_dec;
  logic             fin_rd;
  logic [VTX_W-1:0] fin_q;
  logic             cand;

  assign n_act      = (nv_r > NMAX) ? NMAX : nv_r;
  assign in_ready   = (state_r == S_IDLE);
  assign accept     = in_valid && in_ready;
  assign out_valid  = out_v_r;
  assign out_item   = out_r;
  assign can_emit   = !out_v_r || out_ready;
  assign emit_block = hold_v_r && !can_emit;
  assign key_dec    = key_r - 1'b1;

  assign add_ok = (in_item.src_vertex != '0) && (in_item.src_vertex <= n_act) &&
                  (in_item.dst_vertex != '0) && (in_item.dst_vertex <= n_act) &&
                  (edge_cnt_r != EFULL);

  assign e_wdata = '{src: in_item.src_vertex, dst: in_item.dst_vertex};

  assign ea    = second_r ? edge_q.dst : edge_q.src;
  assign eb    = second_r ? edge_q.src : edge_q.dst;
  assign found = (ea == u_r) && (eb != '0) && (eb <= n_act) && !vis_r[eb[VW-1:0]];
  assign cand  = (fin_q != '0) && (fin_q <= n_act) && !vis_r[fin_q[VW-1:0]];

  scc_edge_mem #(
    .DEPTH (MAX_EDGES),
    .AW    (EAW)
  ) u_edge_mem (
    .clk     (clk),
    .wr_en   (e_we),
    .wr_addr (edge_cnt_r[EAW-1:0]),
    .wr_data (e_wdata),
    .rd_en   (e_rd),
    .rd_addr (c_r[EAW-1:0]),
    .rd_data (edge_q)
  );

  always_ff @(posedge clk) begin
    if (st_we) begin
      stk_mem[sp_r] <= '{vertex: u_r, cursor: c_r + 1'b1};
    end
    if (st_rd) begin
      st_q <= stk_mem[st_raddr];
    end
  end

  assign st_raddr = sp_r - 1'b1;

  always_ff @(posedge clk) begin
    if (fin_we) begin
      fin_mem[key_dec[SW-1:0]] <= u_r;
    end
    if (fin_rd) begin
      fin_q <= fin_mem[idx_r[SW-1:0]];
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && (in_item.kind == KIND_RUN)) begin
          state_nxt = S_P1_NEXT;
        end
      end
      S_P1_NEXT: begin
        if (idx_r > n_act) begin
          state_nxt = S_P2_RD;
        end else if (!vis_r[idx_r[VW-1:0]]) begin
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        if (c_r < edge_cnt_r) begin
          state_nxt = S_CMP;
        end else if (sp_r != '0) begin
          state_nxt = S_POP;
        end else begin
          state_nxt = second_r ? S_P2_RD : S_P1_NEXT;
        end
      end
      S_CMP: begin
        if (!(found && second_r && emit_block)) begin
          state_nxt = S_RD;
        end
      end
      S_POP: begin
        state_nxt = S_RD;
      end
      S_P2_RD: begin
        state_nxt = (idx_r == n_act) ? S_DONE : S_P2_CHK;
      end
      S_P2_CHK: begin
        if (!cand) begin
          state_nxt = S_P2_RD;
        end else if (!emit_block) begin
          state_nxt = S_RD;
        end
      end
      S_DONE: begin
        if (!(hold_v_r && !can_emit)) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    nv_nxt       = cfg_we ? cfg_wdata : nv_r;
    edge_cnt_nxt = edge_cnt_r;
    drop_nxt     = drop_r;
    vis_nxt      = vis_r;
    second_nxt   = second_r;
    idx_nxt      = idx_r;
    key_nxt      = key_r;
    comp_nxt     = comp_r;
    u_nxt        = u_r;
    c_nxt        = c_r;
    sp_nxt       = sp_r;
    hold_nxt     = hold_r;
    hold_v_nxt   = hold_v_r;
    out_nxt      = out_r;
    out_v_nxt    = out_v_r && !out_ready;
    e_we         = 1'b0;
    e_rd         = 1'b0;
    st_we        = 1'b0;
    st_rd        = 1'b0;
    fin_we       = 1'b0;
    fin_rd       = 1'b0;
    emit_req     = 1'b0;
    emit_vtx     = u_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_item.kind)
            KIND_ADD: begin
              if (add_ok) begin
                e_we         = 1'b1;
                edge_cnt_nxt = edge_cnt_r + 1'b1;
              end else begin
                drop_nxt = 1'b1;
              end
            end
            KIND_CLEAR: begin
              edge_cnt_nxt = '0;
              drop_nxt     = 1'b0;
            end
            KIND_RUN: begin
              vis_nxt    = '0;
              idx_nxt    = VTX_W'(1);
              key_nxt    = n_act;
              second_nxt = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      S_P1_NEXT: begin
        if (idx_r > n_act) begin
          vis_nxt    = '0;
          second_nxt = 1'b1;
          idx_nxt    = '0;
          comp_nxt   = '0;
        end else if (vis_r[idx_r[VW-1:0]]) begin
          idx_nxt = idx_r + 1'b1;
        end else begin
          vis_nxt[idx_r[VW-1:0]] = 1'b1;
          u_nxt   = idx_r;
          c_nxt   = '0;
          sp_nxt  = '0;
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_RD: begin
        if (c_r < edge_cnt_r) begin
          e_rd = 1'b1;
        end else begin
          if (!second_r && (key_r != '0)) begin
            fin_we  = 1'b1;
            key_nxt = key_dec;
          end
          if (sp_r != '0) begin
            st_rd  = 1'b1;
            sp_nxt = st_raddr;
          end else if (second_r) begin
            comp_nxt = comp_r + 1'b1;
          end
        end
      end
      S_CMP: begin
        if (found) begin
          if (!(second_r && emit_block)) begin
            st_we  = 1'b1;
            sp_nxt = sp_r + 1'b1;
            vis_nxt[eb[VW-1:0]] = 1'b1;
            u_nxt  = eb;
            c_nxt  = '0;
            if (second_r) begin
              emit_req = 1'b1;
              emit_vtx = eb;
            end
          end
        end else begin
          c_nxt = c_r + 1'b1;
        end
      end
      S_POP: begin
        u_nxt = st_q.vertex;
        c_nxt = st_q.cursor;
      end
      S_P2_RD: begin
        if (idx_r != n_act) begin
          fin_rd = 1'b1;
        end
      end
      S_P2_CHK: begin
        if (!cand) begin
          idx_nxt = idx_r + 1'b1;
        end else if (!emit_block) begin
          vis_nxt[fin_q[VW-1:0]] = 1'b1;
          u_nxt    = fin_q;
          c_nxt    = '0;
          sp_nxt   = '0;
          idx_nxt  = idx_r + 1'b1;
          emit_req = 1'b1;
          emit_vtx = fin_q;
        end
      end
      S_DONE: begin
        if (hold_v_r && can_emit) begin
          out_nxt      = hold_r;
          out_nxt.last = 1'b1;
          out_v_nxt    = 1'b1;
          hold_v_nxt   = 1'b0;
        end
      end
      default: begin
      end
    endcase
    if (emit_req) begin
      if (hold_v_r) begin
        out_nxt   = hold_r;
        out_v_nxt = 1'b1;
      end
      hold_nxt   = '{vertex: emit_vtx, component: comp_r, last: 1'b0, overflow: drop_r};
      hold_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      nv_r       <= NV_RESET;
      edge_cnt_r <= '0;
      drop_r     <= 1'b0;
      hold_v_r   <= 1'b0;
      out_v_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      nv_r       <= nv_nxt;
      edge_cnt_r <= edge_cnt_nxt;
      drop_r     <= drop_nxt;
      hold_v_r   <= hold_v_nxt;
      out_v_r    <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    vis_r    <= vis_nxt;
    second_r <= second_nxt;
    idx_r    <= idx_nxt;
    key_r    <= key_nxt;
    comp_r   <= comp_nxt;
    u_r      <= u_nxt;
    c_r      <= c_nxt;
    sp_r     <= sp_nxt;
    hold_r   <= hold_nxt;
    out_r    <= out_nxt;
  end

endmodule

### hw/rtl/scc_edge_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_edge_mem
// Edge table: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module scc_edge_mem
  import scc_pkg::*;
#(
  parameter int DEPTH = SCC_MAX_EDGES,
  parameter int AW    = 8
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  edge_t         wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output edge_t         rd_data
);

  edge_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### hw/rtl/scc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_checker
// Port-level checks for the strongly connected components block.
// ----------------------------------------------------------------------------
module scc_checker
  import scc_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_item,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_item
);

  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_item.kind == KIND_RUN) |=> !in_ready)
    else $error("ready after run item");

  a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_item.kind == KIND_ADD || in_item.kind == KIND_CLEAR)
    |=> in_ready)
    else $error("not ready after load item");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result item dropped or changed while stalled");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("bad state after reset");

endmodule

bind strongly_connected_components scc_checker u_scc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the strongly connected components block. Loads edge
// tables, runs component searches and checks every reported vertex, its
// component index, the last flag and the overflow flag against an internal
// Kosaraju predictor, under several sender and receiver idling patterns.
// ----------------------------------------------------------------------------
module tb;
  import scc_pkg::*;

  localparam int CYCLE_LIMIT = 16000000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_item;
  logic      cfg_we;
  logic [VTX_W-1:0] cfg_wdata;

  strongly_connected_components u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // graph predictor state
  int        edge_src [SCC_MAX_EDGES];
  int        edge_dst [SCC_MAX_EDGES];
  int        edge_cnt;
  bit        edges_dropped;
  logic [VTX_W-1:0] nv_reg;
  int        act_n;
  int        mark [SCC_MAX_VERTICES+1];
  int        finish_seq [SCC_MAX_VERTICES];
  int        stk_vtx [SCC_MAX_VERTICES];
  int        stk_cur [SCC_MAX_VERTICES];
  out_item_t comp_q [$];

  in_item_t  pending_q [$];
  out_item_t scc_expected_q [$];
  int        send_idle_pct;
  int        recv_stall_pct;
  bit        send_hold;
  int        errors;
  int        cycles;

  function automatic void emit_vertex(int v, int comp);
    out_item_t r;
    r.vertex    = VTX_W'(v);
    r.component = COMP_W'(comp);
    r.last      = 1'b0;
    r.overflow  = edges_dropped;
    comp_q = {comp_q, r};
  endfunction

  function automatic void dfs_walk(int root, bit second, int comp, inout int key);
    int top, u, c, found, a, b;
    mark[root] = 1;
    stk_vtx[0] = root;
    stk_cur[0] = 0;
    top = 1;
    if (second) emit_vertex(root, comp);
    while (top > 0) begin
      u = stk_vtx[top-1];
      c = stk_cur[top-1];
      found = 0;
      while (c < edge_cnt && c < SCC_MAX_EDGES) begin
        a = second ? edge_dst[c] : edge_src[c];
        b = second ? edge_src[c] : edge_dst[c];
        c++;
        if (a == u && b >= 1 && b <= act_n && mark[b] == 0) begin
          found = b;
          break;
        end
      end
      stk_cur[top-1] = c;
      if (found != 0 && top < SCC_MAX_VERTICES) begin
        mark[found] = 1;
        if (second) emit_vertex(found, comp);
        stk_vtx[top] = found;
        stk_cur[top] = 0;
        top++;
      end else begin
        mark[u] = 2;
        top--;
        if (!second && key > 0) begin
          key--;
          finish_seq[key] = u;
        end
      end
    end
  endfunction

  function automatic void predict_components(in_item_t it);
    int s, d, key, comp, u;
    s = int'(it.src_vertex);
    d = int'(it.dst_vertex);
    if (it.kind == KIND_ADD) begin
      if (s < 1 || s > act_n || d < 1 || d > act_n || edge_cnt >= SCC_MAX_EDGES) begin
        edges_dropped = 1'b1;
      end else begin
        edge_src[edge_cnt] = s;
        edge_dst[edge_cnt] = d;
        edge_cnt++;
      end
    end else if (it.kind == KIND_CLEAR) begin
      edge_cnt = 0;
      edges_dropped = 1'b0;
    end else if (it.kind == KIND_RUN) begin
      key = act_n;
      comp = 0;
      comp_q.delete();
      foreach (mark[i]) mark[i] = 0;
      for (int i = 1; i <= act_n; i++)
        if (mark[i] == 0) dfs_walk(i, 1'b0, 0, key);
      foreach (mark[i]) mark[i] = 0;
      for (int i = 0; i < act_n; i++) begin
        u = finish_seq[i];
        if (u >= 1 && u <= act_n && mark[u] == 0) begin
          dfs_walk(u, 1'b1, comp, key);
          comp++;
        end
      end
      if (comp_q.size() > 0) comp_q[$].last = 1'b1;
      foreach (comp_q[i]) scc_expected_q = {scc_expected_q, comp_q[i]};
    end
  endfunction

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_q.size() > 0 && !send_hold &&
          $urandom_range(99) >= send_idle_pct) begin
        in_item  <= pending_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    out_item_t exp_r;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
    if (rst_n) begin
      if (in_valid && in_ready) predict_components(in_item);
      if (out_valid && out_ready) begin
        if (scc_expected_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result: vertex %0d comp %0d last %0d ovf %0d",
                     out_item.vertex, out_item.component, out_item.last,
                     out_item.overflow);
        end else begin
          exp_r = scc_expected_q.pop_front();
          if (out_item.vertex !== exp_r.vertex || out_item.component !== exp_r.component ||
              out_item.last !== exp_r.last || out_item.overflow !== exp_r.overflow) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp v %0d c %0d l %0d o %0d, got v %0d c %0d l %0d o %0d",
                       exp_r.vertex, exp_r.component, exp_r.last, exp_r.overflow,
                       out_item.vertex, out_item.component, out_item.last,
                       out_item.overflow);
          end
        end
      end
    end
  end

  task automatic push_item(logic [KIND_W-1:0] k, int s, int d);
    in_item_t it;
    it.kind       = k;
    it.src_vertex = VTX_W'(s);
    it.dst_vertex = VTX_W'(d);
    pending_q = {pending_q, it};
  endtask

  task automatic wait_idle();
    do begin
      @(posedge clk);
      #1;
    end while (pending_q.size() > 0 || in_valid || !in_ready || out_valid ||
               scc_expected_q.size() > 0);
    repeat (64) @(posedge clk);
  endtask

  task automatic write_nv(int v);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= VTX_W'(v);
    @(posedge clk);
    cfg_we <= 1'b0;
    nv_reg = VTX_W'(v);
    act_n  = (nv_reg > SCC_MAX_VERTICES) ? SCC_MAX_VERTICES : int'(nv_reg);
    @(posedge clk);
  endtask

  function automatic int pick_vertex(int good_pct);
    if (act_n > 0 && $urandom_range(99) < good_pct) return $urandom_range(act_n, 1);
    return $urandom_range(127, 0);
  endfunction

  // optional clear, a burst of edges with random content, run; sometimes noise
  task automatic gen_graphs(int budget);
    int sent, k;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(99) < 85) begin
        if ($urandom_range(3) != 0) begin
          push_item(KIND_CLEAR, $urandom_range(127), $urandom_range(127));
          sent++;
        end
        k = ($urandom_range(7) == 0) ? $urandom_range(40) : $urandom_range(12);
        repeat (k) push_item(KIND_ADD, pick_vertex(92), pick_vertex(92));
        push_item(KIND_RUN, $urandom_range(127), $urandom_range(127));
        sent += k + 1;
      end else begin
        k = $urandom_range(3);
        if (KIND_W'(k) != KIND_RSVD) sent++;
        push_item(KIND_W'(k), $urandom_range(127), $urandom_range(127));
      end
    end
  endtask

  initial begin
    int sp [4] = '{0, 83, 0, 33};
    int rp [4] = '{0, 0, 83, 33};
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    send_hold = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    errors = 0;
    cycles = 0;
    edge_cnt = 0;
    edges_dropped = 1'b0;
    nv_reg = NV_RESET;
    act_n = SCC_MAX_VERTICES;
    foreach (finish_seq[i]) finish_seq[i] = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed
    push_item(KIND_RUN, 0, 0);
    push_item(KIND_ADD, 1, 2);
    push_item(KIND_ADD, 2, 1);
    push_item(KIND_ADD, 1, 2);
    push_item(KIND_ADD, 3, 3);
    push_item(KIND_ADD, 64, 1);
    push_item(KIND_ADD, 0, 5);
    push_item(KIND_ADD, 5, 65);
    push_item(KIND_ADD, 127, 127);
    push_item(KIND_RSVD, 1, 1);
    push_item(KIND_RUN, 127, 127);
    push_item(KIND_CLEAR, 0, 0);
    push_item(KIND_ADD, 40, 2);
    push_item(KIND_ADD, 2, 3);
    push_item(KIND_ADD, 3, 2);
    write_nv(5);
    push_item(KIND_RUN, 0, 0);
    write_nv(0);
    push_item(KIND_RUN, 0, 0);
    push_item(KIND_ADD, 1, 1);
    write_nv(127);
    push_item(KIND_RUN, 0, 0);
    write_nv(1);
    push_item(KIND_CLEAR, 0, 0);
    push_item(KIND_ADD, 1, 1);
    push_item(KIND_RUN, 0, 0);

    for (int ph = 0; ph < 4; ph++) begin
      write_nv((ph == 1) ? 64 : $urandom_range(16, 2));
      send_idle_pct  = sp[ph];
      recv_stall_pct = rp[ph];
      gen_graphs(20);
      if (ph == 0) begin
        // hold off until the block has drained
        send_hold = 1'b1;
        do begin
          @(posedge clk);
          #1;
        end while (in_valid || !in_ready || out_valid || scc_expected_q.size() > 0);
        send_hold = 1'b0;
      end
      if (ph == 1) begin
        push_item(KIND_CLEAR, 0, 0);
        repeat (258) push_item(KIND_ADD, $urandom_range(64, 1), $urandom_range(64, 1));
        push_item(KIND_RUN, 0, 0);
      end
      if (ph == 3) write_nv($urandom_range(127, 65));
      gen_graphs(17);
    end

    wait_idle();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/scc_pkg.sv
hw/rtl/scc_edge_mem.sv
hw/rtl/strongly_connected_components.sv
hw/rtl/scc_checker.sv
tb/sv/tb.sv
